// ----- rtl/core/lpv_pkg.sv -----
package lpv_pkg;

	// Grid and table sizes
	localparam int GRID_X       = 512;
	localparam int GRID_Y       = 512;
	localparam int PILLAR_LIMIT = 32768;
	localparam int MAX_POINTS   = 20;

	localparam int NUM_CELLS = GRID_X * GRID_Y;
	localparam int CX_W      = $clog2(GRID_X);
	localparam int CY_W      = $clog2(GRID_Y);
	localparam int KEY_W     = $clog2(NUM_CELLS);
	localparam int PIL_W     = (PILLAR_LIMIT > 1) ? $clog2(PILLAR_LIMIT) : 1;
	localparam int CNT_W     = $clog2(PILLAR_LIMIT + 1);
	localparam int FILL_W    = $clog2(MAX_POINTS + 1);

	// Frame tag kept in each cell map entry; zero marks an unused cell
	localparam int TAG_W = 8;

	localparam int COORD_W   = 24;
	localparam int INV_W     = 24;
	localparam int PROD_W    = COORD_W + INV_W;
	localparam int CELL_SHIFT = 26;
	localparam int GRID_W    = PROD_W - CELL_SHIFT;

	typedef enum logic [2:0] {
		STS_STORED      = 3'd0,
		STS_OUT_BOX     = 3'd1,
		STS_OUT_GRID    = 3'd2,
		STS_TABLE_FULL  = 3'd3,
		STS_PILLAR_FULL = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_BOX_X_LOW  = 3'd0,
		REG_BOX_X_HIGH = 3'd1,
		REG_BOX_Y_LOW  = 3'd2,
		REG_BOX_Y_HIGH = 3'd3,
		REG_BOX_Z_LOW  = 3'd4,
		REG_BOX_Z_HIGH = 3'd5,
		REG_INV_CELL_X = 3'd6,
		REG_INV_CELL_Y = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CALC,
		S_MUL,
		S_LOOKUP,
		S_MAP,
		S_FILL,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [PIL_W-1:0] pillar;
	} map_entry_t;

endpackage

// ----- rtl/core/lidar_pillar_voxelizer_unit.sv -----
// Pillar voxelizer: one lidar point in, one result out. Each point runs through
// a sequence of steps (box check, cell multiply, cell map read, pillar fill
// read, write back, result load), paced by the registered reads of the cell
// map and pillar fill memories. A point in a known pillar takes every step; one
// that opens a pillar or meets a full table skips the pillar fill read and write
// back, one outside the grid stops before the cell map read and one outside the
// box goes from the box check straight to the result load. The next point is
// taken only once the result is loaded, which waits while the previous result
// is not yet taken. After reset the cell map is swept clean, one entry per cycle
// over all GRID_X * GRID_Y entries (262144), before the first point is taken.
// Frames are told apart by an 8-bit tag in each map entry, so every 255th
// new_frame repeats that sweep before its point is handled. The output register
// holds a result until taken while the next point already enters.
module lidar_pillar_voxelizer_unit
	import lpv_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [23:0]         cfg_data,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic                new_frame,
	input  logic signed [23:0]  pos_x,
	input  logic signed [23:0]  pos_y,
	input  logic signed [23:0]  pos_z,
	input  logic [7:0]          intensity,

	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [14:0]         pillar_index,
	output logic [4:0]          slot,
	output logic                new_pillar,
	output logic [8:0]          cell_x,
	output logic [8:0]          cell_y,
	output logic signed [23:0]  out_x,
	output logic signed [23:0]  out_y,
	output logic signed [23:0]  out_z,
	output logic [15:0]         intensity_scaled,
	output logic [15:0]         pillars_used
);

	localparam logic [TAG_W-1:0] TAG_MAX = {TAG_W{1'b1}};
	localparam logic [TAG_W-1:0] TAG_ONE = TAG_W'(1);

	// Configuration
	logic signed [23:0] box_x_low_q, box_x_high_q;
	logic signed [23:0] box_y_low_q, box_y_high_q;
	logic signed [23:0] box_z_low_q, box_z_high_q;
	logic [INV_W-1:0]   inv_cell_x_q, inv_cell_y_q;

	// Control
	state_t             state_q, state_d;
	logic [KEY_W-1:0]   clr_addr_q;
	logic               pend_q;
	logic [TAG_W-1:0]   frame_tag_q;
	logic [CNT_W-1:0]   pillar_count_q;
	logic               out_valid_q;

	// Working item
	logic signed [23:0] x_q, y_q, z_q;
	logic [7:0]         inten_q;
	logic [23:0]        diff_x_q, diff_y_q;
	logic [GRID_W-1:0]  gx_q, gy_q;
	logic [CX_W-1:0]    cx_q;
	logic [CY_W-1:0]    cy_q;
	status_t            status_q;
	logic [PIL_W-1:0]   pillar_q;
	logic [FILL_W-1:0]  slot_q;
	logic               opened_q;

	// Result register
	status_t            res_status_q;
	logic [PIL_W-1:0]   res_pillar_q;
	logic [FILL_W-1:0]  res_slot_q;
	logic               res_opened_q;
	logic [CX_W-1:0]    res_cx_q;
	logic [CY_W-1:0]    res_cy_q;
	logic signed [23:0] res_x_q, res_y_q, res_z_q;
	logic [7:0]         res_inten_q;
	logic [CNT_W-1:0]   res_count_q;

	// Memories
	map_entry_t         cell_map_mem [NUM_CELLS];
	logic [FILL_W-1:0]  pillar_fill_mem [PILLAR_LIMIT];
	map_entry_t         map_rdata_q;
	logic [FILL_W-1:0]  fill_rdata_q;

	logic               map_re, map_we;
	logic [KEY_W-1:0]   map_addr;
	map_entry_t         map_wdata;
	logic               fill_re, fill_we;
	logic [PIL_W-1:0]   fill_addr;
	logic [FILL_W-1:0]  fill_wdata;

	logic               in_fire, wrap, clr_last, res_load;
	logic               in_box, in_grid, map_hit, table_full, pillar_full;
	logic [24:0]        dx, dy;
	logic [PROD_W-1:0]  prod_x, prod_y;
	logic [KEY_W-1:0]   key;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && in_ready;
	assign wrap      = new_frame && (frame_tag_q == TAG_MAX);
	assign clr_last  = (clr_addr_q == KEY_W'(NUM_CELLS - 1));
	assign res_load  = (state_q == S_OUT) && (!out_valid_q || out_ready);

	assign in_box = (x_q >= box_x_low_q) && (x_q <= box_x_high_q) &&
	                (y_q >= box_y_low_q) && (y_q <= box_y_high_q) &&
	                (z_q >= box_z_low_q) && (z_q <= box_z_high_q);
	assign dx = {x_q[23], x_q} - {box_x_low_q[23], box_x_low_q};
	assign dy = {y_q[23], y_q} - {box_y_low_q[23], box_y_low_q};

	assign prod_x = diff_x_q * inv_cell_x_q;
	assign prod_y = diff_y_q * inv_cell_y_q;

	assign in_grid = (gx_q < GRID_W'(GRID_X)) && (gy_q < GRID_W'(GRID_Y));
	assign key     = KEY_W'(gy_q) * KEY_W'(GRID_X) + KEY_W'(gx_q);

	assign map_hit     = (map_rdata_q.tag == frame_tag_q);
	assign table_full  = (pillar_count_q >= CNT_W'(PILLAR_LIMIT));
	assign pillar_full = (fill_rdata_q >= FILL_W'(MAX_POINTS));

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		map_re     = 1'b0;
		map_we     = 1'b0;
		map_addr   = key;
		map_wdata  = '{tag: frame_tag_q, pillar: PIL_W'(pillar_count_q)};
		fill_re    = 1'b0;
		fill_we    = 1'b0;
		fill_addr  = pillar_q;
		fill_wdata = FILL_W'(fill_rdata_q + 1'b1);
		case (state_q)
			S_CLEAR: begin
				map_we    = 1'b1;
				map_addr  = clr_addr_q;
				map_wdata = '0;
				if (clr_last) begin
					state_d = pend_q ? S_CALC : S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = wrap ? S_CLEAR : S_CALC;
				end
			end
			S_CALC: begin
				state_d = in_box ? S_MUL : S_OUT;
			end
			S_MUL: begin
				state_d = S_LOOKUP;
			end
			S_LOOKUP: begin
				if (in_grid) begin
					map_re  = 1'b1;
					state_d = S_MAP;
				end else begin
					state_d = S_OUT;
				end
			end
			S_MAP: begin
				if (map_hit) begin
					fill_re   = 1'b1;
					fill_addr = map_rdata_q.pillar;
					state_d   = S_FILL;
				end else begin
					if (!table_full) begin
						// open a pillar: map the cell, first point goes to slot 0
						map_we     = 1'b1;
						fill_we    = 1'b1;
						fill_addr  = PIL_W'(pillar_count_q);
						fill_wdata = FILL_W'(1);
					end
					state_d = S_OUT;
				end
			end
			S_FILL: begin
				fill_we = !pillar_full;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_x_low_q  <= -24'sd52429;
			box_x_high_q <= 24'sd52429;
			box_y_low_q  <= -24'sd52429;
			box_y_high_q <= 24'sd52429;
			box_z_low_q  <= -24'sd5120;
			box_z_high_q <= 24'sd3072;
			inv_cell_x_q <= 24'd327680;
			inv_cell_y_q <= 24'd327680;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_BOX_X_LOW:  box_x_low_q  <= cfg_data;
				REG_BOX_X_HIGH: box_x_high_q <= cfg_data;
				REG_BOX_Y_LOW:  box_y_low_q  <= cfg_data;
				REG_BOX_Y_HIGH: box_y_high_q <= cfg_data;
				REG_BOX_Z_LOW:  box_z_low_q  <= cfg_data;
				REG_BOX_Z_HIGH: box_z_high_q <= cfg_data;
				REG_INV_CELL_X: inv_cell_x_q <= cfg_data;
				REG_INV_CELL_Y: inv_cell_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame control and pillar counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q     <= '0;
			pend_q         <= 1'b0;
			frame_tag_q    <= TAG_ONE;
			pillar_count_q <= '0;
		end else begin
			if (state_q == S_CLEAR) begin
				if (clr_last) begin
					clr_addr_q  <= '0;
					pend_q      <= 1'b0;
					frame_tag_q <= TAG_ONE;
				end else begin
					clr_addr_q <= KEY_W'(clr_addr_q + 1'b1);
				end
			end
			if (in_fire && new_frame) begin
				pillar_count_q <= '0;
				if (wrap) begin
					pend_q <= 1'b1;
				end else begin
					frame_tag_q <= TAG_W'(frame_tag_q + 1'b1);
				end
			end
			if (state_q == S_MAP && !map_hit && !table_full) begin
				pillar_count_q <= CNT_W'(pillar_count_q + 1'b1);
			end
		end
	end

	// Item datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q      <= pos_x;
			y_q      <= pos_y;
			z_q      <= pos_z;
			inten_q  <= intensity;
			status_q <= STS_STORED;
			pillar_q <= '0;
			slot_q   <= '0;
			opened_q <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
		end
		case (state_q)
			S_CALC: begin
				diff_x_q <= dx[23:0];
				diff_y_q <= dy[23:0];
				if (!in_box) begin
					status_q <= STS_OUT_BOX;
				end
			end
			S_MUL: begin
				gx_q <= prod_x[PROD_W-1:CELL_SHIFT];
				gy_q <= prod_y[PROD_W-1:CELL_SHIFT];
			end
			S_LOOKUP: begin
				if (in_grid) begin
					cx_q <= CX_W'(gx_q);
					cy_q <= CY_W'(gy_q);
				end else begin
					status_q <= STS_OUT_GRID;
				end
			end
			S_MAP: begin
				if (map_hit) begin
					pillar_q <= map_rdata_q.pillar;
				end else if (table_full) begin
					status_q <= STS_TABLE_FULL;
				end else begin
					pillar_q <= PIL_W'(pillar_count_q);
					opened_q <= 1'b1;
				end
			end
			S_FILL: begin
				if (pillar_full) begin
					status_q <= STS_PILLAR_FULL;
				end else begin
					slot_q <= fill_rdata_q;
				end
			end
			default: ;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= status_q;
			res_pillar_q <= pillar_q;
			res_slot_q   <= slot_q;
			res_opened_q <= opened_q;
			res_cx_q     <= cx_q;
			res_cy_q     <= cy_q;
			res_x_q      <= x_q;
			res_y_q      <= y_q;
			res_z_q      <= z_q;
			res_inten_q  <= inten_q;
			res_count_q  <= pillar_count_q;
		end
	end

	// Cell map memory
	always_ff @(posedge clk) begin
		if (map_we) begin
			cell_map_mem[map_addr] <= map_wdata;
		end
		if (map_re) begin
			map_rdata_q <= cell_map_mem[map_addr];
		end
	end

	// Pillar fill memory
	always_ff @(posedge clk) begin
		if (fill_we) begin
			pillar_fill_mem[fill_addr] <= fill_wdata;
		end
		if (fill_re) begin
			fill_rdata_q <= pillar_fill_mem[fill_addr];
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = res_status_q;
	assign pillar_index     = 15'(res_pillar_q);
	assign slot             = 5'(res_slot_q);
	assign new_pillar       = res_opened_q;
	assign cell_x           = 9'(res_cx_q);
	assign cell_y           = 9'(res_cy_q);
	assign out_x            = res_x_q;
	assign out_y            = res_y_q;
	assign out_z            = res_z_q;
	assign intensity_scaled = {res_inten_q, res_inten_q};
	assign pillars_used     = 16'(res_count_q);

endmodule

// ----- bench/lidar_pillar_voxelizer_unit_tb.sv -----
module lidar_pillar_voxelizer_unit_tb;
	import lpv_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	typedef int reg_set_t [8];

	typedef struct {
		status_t            status;
		logic [14:0]        pillar_index;
		logic [4:0]         slot;
		logic               new_pillar;
		logic [8:0]         cell_x;
		logic [8:0]         cell_y;
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic signed [23:0] out_z;
		logic [15:0]        intensity_scaled;
		logic [15:0]        pillars_used;
	} voxel_result_t;

	class voxel_tracker;
		int          box_lo [3];
		int          box_hi [3];
		int unsigned inv_x;
		int unsigned inv_y;
		// A cell belongs to the current frame only when its stamp matches.
		bit [31:0]   cell_stamp [NUM_CELLS];
		bit [14:0]   cell_pillar [NUM_CELLS];
		bit [5:0]    pillar_fill [PILLAR_LIMIT];
		bit [31:0]   frame_no;
		int unsigned pillars_open;
		voxel_result_t results_due [$];
		int          mismatches;

		function new();
			box_lo = '{-52429, -52429, -5120};
			box_hi = '{52429, 52429, 3072};
			inv_x = 327680;
			inv_y = 327680;
			frame_no = 1;
			pillars_open = 0;
			mismatches = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [23:0] data);
			case (idx)
			REG_BOX_X_LOW:  box_lo[0] = int'(signed'(data));
			REG_BOX_X_HIGH: box_hi[0] = int'(signed'(data));
			REG_BOX_Y_LOW:  box_lo[1] = int'(signed'(data));
			REG_BOX_Y_HIGH: box_hi[1] = int'(signed'(data));
			REG_BOX_Z_LOW:  box_lo[2] = int'(signed'(data));
			REG_BOX_Z_HIGH: box_hi[2] = int'(signed'(data));
			REG_INV_CELL_X: inv_x = 32'(data);
			REG_INV_CELL_Y: inv_y = 32'(data);
			default: ;
			endcase
		endfunction

		function void bin_point(bit nf, logic signed [23:0] x, logic signed [23:0] y,
				logic signed [23:0] z, logic [7:0] inten);
			voxel_result_t r;
			int          p [3];
			longint      gx;
			longint      gy;
			int unsigned key;
			bit          outside;
			r.status = STS_STORED;
			r.pillar_index = '0;
			r.slot = '0;
			r.new_pillar = 1'b0;
			r.cell_x = '0;
			r.cell_y = '0;
			p[0] = int'(x);
			p[1] = int'(y);
			p[2] = int'(z);
			if (nf) begin
				frame_no++;
				pillars_open = 0;
			end
			outside = 1'b0;
			for (int a = 0; a < 3; a++)
				if (p[a] < box_lo[a] || p[a] > box_hi[a])
					outside = 1'b1;
			if (outside) begin
				r.status = STS_OUT_BOX;
			end else begin
				gx = ((longint'(p[0]) - longint'(box_lo[0])) * longint'(inv_x)) >>> CELL_SHIFT;
				gy = ((longint'(p[1]) - longint'(box_lo[1])) * longint'(inv_y)) >>> CELL_SHIFT;
				if (gx >= GRID_X || gy >= GRID_Y) begin
					r.status = STS_OUT_GRID;
				end else begin
					key = 32'(gy * GRID_X + gx);
					r.cell_x = 9'(gx);
					r.cell_y = 9'(gy);
					if (cell_stamp[key] != frame_no) begin
						if (pillars_open >= PILLAR_LIMIT) begin
							r.status = STS_TABLE_FULL;
						end else begin
							cell_stamp[key] = frame_no;
							cell_pillar[key] = 15'(pillars_open);
							pillar_fill[pillars_open] = '0;
							r.pillar_index = 15'(pillars_open);
							r.new_pillar = 1'b1;
							pillars_open++;
						end
					end else begin
						r.pillar_index = cell_pillar[key];
					end
					if (r.status == STS_STORED) begin
						if (pillar_fill[r.pillar_index] >= MAX_POINTS) begin
							r.status = STS_PILLAR_FULL;
						end else begin
							r.slot = 5'(pillar_fill[r.pillar_index]);
							pillar_fill[r.pillar_index]++;
						end
					end
				end
			end
			r.out_x = x;
			r.out_y = y;
			r.out_z = z;
			r.intensity_scaled = 16'(inten) * 16'd257;
			r.pillars_used = 16'(pillars_open);
			results_due = {results_due, r};
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void match_result(voxel_result_t got);
			voxel_result_t e;
			if (results_due.size() == 0) begin
				$error("result beat with no point outstanding");
				mismatches++;
				return;
			end
			e = results_due.pop_front();
			compare("status", 32'(e.status), 32'(got.status));
			compare("pillar_index", 32'(e.pillar_index), 32'(got.pillar_index));
			compare("slot", 32'(e.slot), 32'(got.slot));
			compare("new_pillar", 32'(e.new_pillar), 32'(got.new_pillar));
			compare("cell_x", 32'(e.cell_x), 32'(got.cell_x));
			compare("cell_y", 32'(e.cell_y), 32'(got.cell_y));
			compare("out_x", 32'(e.out_x), 32'(got.out_x));
			compare("out_y", 32'(e.out_y), 32'(got.out_y));
			compare("out_z", 32'(e.out_z), 32'(got.out_z));
			compare("intensity_scaled", 32'(e.intensity_scaled), 32'(got.intensity_scaled));
			compare("pillars_used", 32'(e.pillars_used), 32'(got.pillars_used));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	cfg_reg_t           cfg_index;
	logic [23:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic               new_frame;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_y;
	logic signed [23:0] pos_z;
	logic [7:0]         intensity;
	logic               out_valid;
	logic               out_ready;
	logic [2:0]         status;
	logic [14:0]        pillar_index;
	logic [4:0]         slot;
	logic               new_pillar;
	logic [8:0]         cell_x;
	logic [8:0]         cell_y;
	logic signed [23:0] out_x;
	logic signed [23:0] out_y;
	logic signed [23:0] out_z;
	logic [15:0]        intensity_scaled;
	logic [15:0]        pillars_used;

	voxel_tracker sb;
	int           src_idle_pct;
	int           dst_idle_pct;
	int unsigned  cycle_count = 0;

	lidar_pillar_voxelizer_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.new_frame        (new_frame),
		.pos_x            (pos_x),
		.pos_y            (pos_y),
		.pos_z            (pos_z),
		.intensity        (intensity),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.pillar_index     (pillar_index),
		.slot             (slot),
		.new_pillar       (new_pillar),
		.cell_x           (cell_x),
		.cell_y           (cell_y),
		.out_x            (out_x),
		.out_y            (out_y),
		.out_z            (out_z),
		.intensity_scaled (intensity_scaled),
		.pillars_used     (pillars_used)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			voxel_result_t got;
			got.status = status_t'(status);
			got.pillar_index = pillar_index;
			got.slot = slot;
			got.new_pillar = new_pillar;
			got.cell_x = cell_x;
			got.cell_y = cell_y;
			got.out_x = out_x;
			got.out_y = out_y;
			got.out_z = out_z;
			got.intensity_scaled = intensity_scaled;
			got.pillars_used = pillars_used;
			sb.match_result(got);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_point(bit nf, logic signed [23:0] x, logic signed [23:0] y,
			logic signed [23:0] z, logic [7:0] inten);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		new_frame <= nf;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		intensity <= inten;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.bin_point(nf, x, y, z, inten);
	endtask

	// Drop valid and wait for every outstanding result.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.results_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic configure(input reg_set_t vals);
		cfg_reg_t idx;
		idx = REG_BOX_X_LOW;
		for (int i = 0; i < idx.num(); i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data <= 24'(vals[i]);
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.set_reg(idx, 24'(vals[i]));
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic int unsigned pick_column();
		// Mostly inside the grid, now and then near or past its far edge.
		return ($urandom_range(9) == 0) ? $urandom_range(505, 520) : $urandom_range(511);
	endfunction

	// Coordinate that lands in (or near) grid column/row col along one axis.
	function automatic logic signed [23:0] coord_in_column(int lo, int hi, int unsigned inv,
			int unsigned col);
		longint v;
		v = longint'(lo) +
			((longint'(col) << CELL_SHIFT) + longint'($urandom_range(32'h3FF_FFFF))) /
			longint'(inv);
		if (v > hi)
			v = hi;
		if (v > 8388607)
			v = 8388607;
		return 24'(v);
	endfunction

	task automatic random_points(int count, int nf_pct);
		int unsigned        hot_x [3];
		int unsigned        hot_y [3];
		int unsigned        nhx;
		int unsigned        nhy;
		bit                 nf;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
		nhx = 1;
		nhy = 1;
		for (int n = 0; n < count; n++) begin
			nf = ($urandom_range(99) < nf_pct);
			if (nf || n == 0) begin
				nhx = $urandom_range(1, 3);
				nhy = $urandom_range(1, 3);
				for (int k = 0; k < 3; k++) begin
					hot_x[k] = pick_column();
					hot_y[k] = pick_column();
				end
			end
			if ($urandom_range(99) < 80) begin
				x = coord_in_column(sb.box_lo[0], sb.box_hi[0], sb.inv_x,
					hot_x[$urandom_range(nhx - 1)]);
				y = coord_in_column(sb.box_lo[1], sb.box_hi[1], sb.inv_y,
					hot_y[$urandom_range(nhy - 1)]);
				if (sb.box_lo[2] <= sb.box_hi[2])
					z = 24'(sb.box_lo[2] + int'($urandom_range(sb.box_hi[2] - sb.box_lo[2])));
				else
					z = 24'($urandom);
			end else begin
				x = 24'($urandom);
				y = 24'($urandom);
				z = 24'($urandom);
			end
			send_point(nf, x, y, z, 8'($urandom));
		end
	endtask

	initial begin
		sb = new();
		src_idle_pct = 6;
		dst_idle_pct = 47;
		arst_n <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_BOX_X_LOW;
		cfg_data <= '0;
		in_valid <= 1'b0;
		new_frame <= 1'b0;
		pos_x <= '0;
		pos_y <= '0;
		pos_z <= '0;
		intensity <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed points against the reset box and cell size.
		send_point(1'b1, -24'sd52429, -24'sd52429, -24'sd5120, 8'h00);
		send_point(1'b0, 24'sd52428, 24'sd52428, 24'sd3072, 8'hFF);
		send_point(1'b0, 24'sd52429, 24'sd0, 24'sd0, 8'h55);
		send_point(1'b0, 24'sd0, 24'sd52429, 24'sd0, 8'hAA);
		send_point(1'b0, -24'sd52430, 24'sd0, 24'sd0, 8'h01);
		send_point(1'b0, 24'sd0, 24'sd52430, 24'sd0, 8'h02);
		send_point(1'b0, 24'sd0, 24'sd0, -24'sd5121, 8'h40);
		send_point(1'b0, 24'sd0, 24'sd0, 24'sd3073, 8'h20);
		send_point(1'b0, -24'sd8388608, -24'sd8388608, -24'sd8388608, 8'h80);
		send_point(1'b0, 24'sd8388607, 24'sd8388607, 24'sd8388607, 8'h7F);
		send_point(1'b1, -24'sd52429, -24'sd52429, 24'sd0, 8'h10);
		send_point(1'b0, -24'sd52300, -24'sd52400, 24'sd100, 8'h08);
		settle();

		// Inverted x bounds: nothing passes the box.
		configure('{1000, -1000, -52429, 52429, -5120, 3072, 327680, 327680});
		send_point(1'b0, -24'sd1000, 24'sd0, 24'sd0, 8'h11);
		send_point(1'b0, 24'sd0, 24'sd0, 24'sd0, 8'h22);
		send_point(1'b0, 24'sd1000, 24'sd0, 24'sd0, 8'h33);
		send_point(1'b0, 24'sd500, 24'sd0, 24'sd0, 8'h44);
		settle();

		configure('{-52429, 52429, -52429, 52429, -5120, 3072, 327680, 163840});
		random_points(190, 4);
		settle();

		src_idle_pct = 47;
		dst_idle_pct = 6;
		configure('{-8388608, 8388607, -8388608, 8388607, -8388608, 8388607, 1, 65536});
		random_points(190, 4);
		settle();

		src_idle_pct = 0;
		dst_idle_pct = 0;
		// Every point opens a frame, enough to wrap the frame stamps in the map.
		configure('{-1000, 1000, 8088607, 8388607, -8388608, -100, 16777215, 327680});
		random_points(260, 100);
		random_points(190, 4);
		settle();

		// One cell per 1024 units on both axes; fill one pillar past its point limit.
		configure('{0, 8388607, 0, 8388607, -8388608, 8388607, 65536, 65536});
		for (int i = 0; i < MAX_POINTS + 1; i++)
			send_point(i == 0, 24'((5 << 10) + $urandom_range(1023)), 24'($urandom_range(1023)),
				24'($urandom), 8'($urandom));
		send_point(1'b0, 24'sd8388607, 24'sd0, 24'sd0, 8'h5A);
		send_point(1'b1, 24'((5 << 10) + $urandom_range(1023)), 24'($urandom_range(1023)),
			24'($urandom), 8'hA5);
		settle();

		repeat (50) @(posedge clk);
		if (sb.mismatches == 0 && sb.results_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
